FILE: hdl/php_pkg.sv
// php_pkg: shared types and constants for the P6 header parser.
// Used by php_if.sv, php_parse.sv and ppm_header_parser_core.sv.
package php_pkg;

  localparam int DIMENSION_BITS_DEF = 16;
  localparam int OFFSET_BITS_DEF    = 32;

  localparam logic [7:0] CHAR_P     = 8'h50;  // 'P'
  localparam logic [7:0] CHAR_SIX   = 8'h36;  // '6'
  localparam logic [7:0] CHAR_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CHAR_LF    = 8'h0A;  // '\n'
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam int         SAMPLE_LIMIT = 255;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_MAGIC       = 2'd1,
    ST_MALFORMED   = 2'd2,
    ST_UNSUPPORTED = 2'd3
  } status_t;

  typedef enum logic [6:0] {
    PH_MAGIC0     = 7'b0000001,
    PH_MAGIC1     = 7'b0000010,
    PH_MAGIC1_BAD = 7'b0000100,
    PH_SKIP       = 7'b0001000,
    PH_COMMENT    = 7'b0010000,
    PH_DIGITS     = 7'b0100000,
    PH_DONE       = 7'b1000000
  } phase_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

FILE: hdl/php_if.sv
// php_if: valid/ready stream interfaces for the header parser.
// php_in_if carries file bytes, php_out_if carries header results; uses php_pkg.
interface php_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface php_out_if #(
  parameter int DIMENSION_BITS = php_pkg::DIMENSION_BITS_DEF,
  parameter int OFFSET_BITS    = php_pkg::OFFSET_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [DIMENSION_BITS-1:0] image_width;
  logic [DIMENSION_BITS-1:0] image_height;
  logic [7:0]                sample_max;
  logic [OFFSET_BITS-1:0]    data_offset;

  modport source (output valid, output status, output image_width, output image_height,
                  output sample_max, output data_offset, input ready);
  modport sink   (input valid, input status, input image_width, input image_height,
                  input sample_max, input data_offset, output ready);
endinterface

FILE: hdl/ppm_header_parser_core.sv
// ppm_header_parser_core: top level of the binary P6 header parser.
// Uses php_pkg, php_if (php_in_if, php_out_if), php_parse and php_out_buf.
//
//   channel  | dir | payload                                          | handshake
//   ---------+-----+--------------------------------------------------+-----------
//   bytes    | in  | data_byte[7:0], end_of_file                      | valid/ready
//   header   | out | status[1:0], image_width, image_height,          | valid/ready
//            |     | sample_max[7:0], data_offset                     |
//
// One item per cycle while bytes.ready is high: each byte updates the parser
// state in the cycle it is accepted, and any result lands at that same edge in
// the output register, or the skid register while header stalls; header is driven from the output register.
// Reset (rst, synchronous) returns the parser to the first magic byte and
// empties the output register and the skid register.
// bytes.ready drops only while both the output register and the skid
// register hold a result; it depends on no combinational path from header.ready.
module ppm_header_parser_core #(
  parameter int DIMENSION_BITS = php_pkg::DIMENSION_BITS_DEF,
  parameter int OFFSET_BITS    = php_pkg::OFFSET_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  php_in_if.sink   bytes,
  php_out_if.source header
);

  // packed result: status, width, height, sample max, offset
  localparam int RES_W = 2 + 2 * DIMENSION_BITS + 8 + OFFSET_BITS;

  logic                      accept;
  logic                      room;
  logic                      res_valid;
  logic [1:0]                res_status;
  logic [DIMENSION_BITS-1:0] res_width;
  logic [DIMENSION_BITS-1:0] res_height;
  logic [7:0]                res_sample;
  logic [OFFSET_BITS-1:0]    res_offset;
  logic [RES_W-1:0]          out_data;

  assign bytes.ready = room;
  assign accept      = bytes.valid && room;

  php_parse #(
    .DIMENSION_BITS (DIMENSION_BITS),
    .OFFSET_BITS    (OFFSET_BITS)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (bytes.data_byte),
    .end_of_file (bytes.end_of_file),
    .res_valid   (res_valid),
    .res_status  (res_status),
    .res_width   (res_width),
    .res_height  (res_height),
    .res_sample  (res_sample),
    .res_offset  (res_offset)
  );

  php_out_buf #(
    .WIDTH (RES_W)
  ) u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data ({res_status, res_width, res_height, res_sample, res_offset}),
    .room      (room),
    .out_valid (header.valid),
    .out_ready (header.ready),
    .out_data  (out_data)
  );

  assign {header.status, header.image_width, header.image_height,
          header.sample_max, header.data_offset} = out_data;

endmodule

FILE: hdl/php_parse.sv
// php_parse: header state machine; one byte or end-of-file mark per accepted item.
// Depends on php_pkg.
module php_parse #(
  parameter int DIMENSION_BITS = php_pkg::DIMENSION_BITS_DEF,
  parameter int OFFSET_BITS    = php_pkg::OFFSET_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [7:0]                data_byte,
  input  logic                      end_of_file,
  output logic                      res_valid,
  output logic [1:0]                res_status,
  output logic [DIMENSION_BITS-1:0] res_width,
  output logic [DIMENSION_BITS-1:0] res_height,
  output logic [7:0]                res_sample,
  output logic [OFFSET_BITS-1:0]    res_offset
);

  localparam int AW = DIMENSION_BITS + 1;   // accumulator holds up to 2^DIMENSION_BITS
  localparam int MW = AW + 4;               // room for acc*10+9
  localparam logic [AW-1:0] ACC_CAP = AW'(1) << DIMENSION_BITS;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  php_pkg::phase_t           phase, phase_next;
  logic [1:0]                token_number, token_number_next;
  logic [AW-1:0]             accumulator, accumulator_next;
  logic [DIMENSION_BITS-1:0] saved_width, saved_width_next;
  logic [DIMENSION_BITS-1:0] saved_height, saved_height_next;
  logic [OFFSET_BITS-1:0]    bytes_seen, bytes_seen_next;

  logic [OFFSET_BITS-1:0]    bytes_inc;
  logic [3:0]                digit;
  logic [MW-1:0]             acc_mul;
  logic [AW-1:0]             acc_sat;
  logic [DIMENSION_BITS-1:0] acc_dim;
  logic                      final_bad;
  logic                      do_skip;

  assign bytes_inc = (bytes_seen == OFF_MAX) ? bytes_seen : bytes_seen + 1'b1;
  assign digit     = 4'(data_byte - php_pkg::CHAR_ZERO);
  assign acc_mul   = {accumulator, 3'b000} + {2'b00, accumulator, 1'b0} + MW'(digit);
  assign acc_sat   = (acc_mul > MW'(ACC_CAP)) ? ACC_CAP : acc_mul[AW-1:0];
  // zero or over-range dimensions are stored as zero
  assign acc_dim   = (accumulator[DIMENSION_BITS] || accumulator == '0)
                     ? '0 : accumulator[DIMENSION_BITS-1:0];
  assign final_bad = (saved_width == '0) || (saved_height == '0) || (accumulator == '0)
                     || (accumulator > AW'(php_pkg::SAMPLE_LIMIT));

  always_comb begin
    phase_next        = phase;
    token_number_next = token_number;
    accumulator_next  = accumulator;
    saved_width_next  = saved_width;
    saved_height_next = saved_height;
    bytes_seen_next   = bytes_seen;
    res_valid         = 1'b0;
    res_status        = php_pkg::ST_OK;
    res_width         = '0;
    res_height        = '0;
    res_sample        = '0;
    res_offset        = '0;
    do_skip           = 1'b0;

    if (accept) begin
      if (end_of_file) begin
        case (phase)
          php_pkg::PH_MAGIC0, php_pkg::PH_MAGIC1, php_pkg::PH_MAGIC1_BAD: begin
            res_valid  = 1'b1;
            res_status = php_pkg::ST_MAGIC;
          end
          php_pkg::PH_SKIP, php_pkg::PH_COMMENT: begin
            res_valid  = 1'b1;
            res_status = php_pkg::ST_MALFORMED;
          end
          php_pkg::PH_DIGITS: begin
            res_valid = 1'b1;
            if (!token_number[1]) begin
              res_status = php_pkg::ST_MALFORMED;
            end else if (final_bad) begin
              res_status = php_pkg::ST_UNSUPPORTED;
            end else begin
              res_width  = saved_width;
              res_height = saved_height;
              res_sample = accumulator[7:0];
              res_offset = bytes_seen;
            end
          end
          default: begin
          end
        endcase
        phase_next        = php_pkg::PH_MAGIC0;
        token_number_next = '0;
        accumulator_next  = '0;
        saved_width_next  = '0;
        saved_height_next = '0;
        bytes_seen_next   = '0;
      end else if (phase != php_pkg::PH_DONE) begin
        bytes_seen_next = bytes_inc;
        case (phase)
          php_pkg::PH_MAGIC0: begin
            phase_next = (data_byte == php_pkg::CHAR_P) ? php_pkg::PH_MAGIC1
                                                        : php_pkg::PH_MAGIC1_BAD;
          end
          php_pkg::PH_MAGIC1: begin
            if (data_byte != php_pkg::CHAR_SIX) begin
              res_valid  = 1'b1;
              res_status = php_pkg::ST_MAGIC;
              phase_next = php_pkg::PH_DONE;
            end else begin
              phase_next        = php_pkg::PH_SKIP;
              token_number_next = '0;
            end
          end
          php_pkg::PH_MAGIC1_BAD: begin
            res_valid  = 1'b1;
            res_status = php_pkg::ST_MAGIC;
            phase_next = php_pkg::PH_DONE;
          end
          php_pkg::PH_SKIP: begin
            do_skip = 1'b1;
          end
          php_pkg::PH_COMMENT: begin
            if (data_byte == php_pkg::CHAR_LF) begin
              phase_next = php_pkg::PH_SKIP;
            end
          end
          php_pkg::PH_DIGITS: begin
            if (php_pkg::is_digit(data_byte)) begin
              accumulator_next = acc_sat;
            end else if (token_number[1]) begin
              // byte after maxval is the last header byte
              res_valid  = 1'b1;
              phase_next = php_pkg::PH_DONE;
              if (final_bad) begin
                res_status = php_pkg::ST_UNSUPPORTED;
              end else begin
                res_width  = saved_width;
                res_height = saved_height;
                res_sample = accumulator[7:0];
                res_offset = bytes_inc;
              end
            end else begin
              if (token_number == 2'd0) begin
                saved_width_next = acc_dim;
              end else begin
                saved_height_next = acc_dim;
              end
              token_number_next = token_number + 2'd1;
              accumulator_next  = '0;
              do_skip           = 1'b1;   // terminator is re-examined as skip byte
            end
          end
          default: begin
          end
        endcase

        if (do_skip) begin
          if (php_pkg::is_blank(data_byte)) begin
            phase_next = php_pkg::PH_SKIP;
          end else if (data_byte == php_pkg::CHAR_HASH) begin
            phase_next = php_pkg::PH_COMMENT;
          end else if (php_pkg::is_digit(data_byte)) begin
            accumulator_next = AW'(digit);
            phase_next       = php_pkg::PH_DIGITS;
          end else begin
            res_valid  = 1'b1;
            res_status = php_pkg::ST_MALFORMED;
            phase_next = php_pkg::PH_DONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= php_pkg::PH_MAGIC0;
      token_number <= '0;
      accumulator  <= '0;
      saved_width  <= '0;
      saved_height <= '0;
      bytes_seen   <= '0;
    end else begin
      phase        <= phase_next;
      token_number <= token_number_next;
      accumulator  <= accumulator_next;
      saved_width  <= saved_width_next;
      saved_height <= saved_height_next;
      bytes_seen   <= bytes_seen_next;
    end
  end

endmodule

FILE: hdl/php_out_buf.sv
// php_out_buf: output register plus skid register for the result stream.
// Generic over payload width; no package dependencies.
module php_out_buf #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             skid_valid;
  logic [WIDTH-1:0] skid_data;

  // push new items only while the skid slot is free; not enforced here
  assign room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (push) begin
        if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_ready) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!out_valid || out_ready) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end else if (out_ready && skid_valid) begin
      out_data <= skid_data;
    end
  end

endmodule

FILE: bench/ppm_header_parser_core_test.sv
// ppm_header_parser_core_test: self-checking bench for the P6 header parser core.
// Streams file bytes through php_in_if, predicts each header result (or takes a pinned
// one) and checks php_out_if results in order. Depends on php_pkg, php_if.sv and the core RTL.
module ppm_header_parser_core_test;

  localparam int DIM_W = php_pkg::DIMENSION_BITS_DEF;
  localparam int OFF_W = php_pkg::OFFSET_BITS_DEF;

  localparam int N_DIRECTED   = 31;
  localparam int RANDOM_BYTES = 1250;
  localparam int MAX_REPORTS  = 10;

  // Bytes not named in the package
  localparam logic [7:0] CHAR_VT = 8'h0B;
  localparam logic [7:0] CHAR_FF = 8'h0C;
  localparam logic [7:0] CHAR_X  = 8'h78;   // 'x'

  // One header result as the output channel carries it
  typedef struct packed {
    php_pkg::status_t  status;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [7:0]        sample_max;
    logic [OFF_W-1:0]  offset;
  } header_t;

  // One item on the byte channel, plus bench bookkeeping:
  // pinned - the expected header is typed in below instead of predicted
  // drain  - hold off until every pending header has come back first
  typedef struct packed {
    logic [7:0] data_byte;
    logic       eof;
    logic       pinned;
    logic       drain;
    header_t    want;
  } file_item_t;

  localparam header_t NO_HDR     = '0;
  localparam header_t HDR_MAGIC  = '{php_pkg::ST_MAGIC, '0, '0, '0, '0};
  localparam header_t HDR_BROKEN = '{php_pkg::ST_MALFORMED, '0, '0, '0, '0};
  localparam header_t HDR_UNSUP  = '{php_pkg::ST_UNSUPPORTED, '0, '0, '0, '0};
  localparam header_t HDR_9X7    = '{php_pkg::ST_OK, 16'd9, 16'd7, 8'd255, 32'd13};

  // Directed stimulus. Only results that are obvious at a glance are typed in.
  localparam file_item_t DIRECTED_ROWS [N_DIRECTED] = '{
    // end of file with no bytes at all: bad magic
    '{8'h00,                      1'b1, 1'b1, 1'b0, HDR_MAGIC},
    // wrong first magic byte: second byte still taken, then bad magic
    '{8'hFF,                      1'b0, 1'b0, 1'b0, NO_HDR},
    '{8'h00,                      1'b0, 1'b1, 1'b0, HDR_MAGIC},
    // end of file after a result: silent rearm
    '{8'h00,                      1'b1, 1'b0, 1'b0, NO_HDR},
    // full header: comment, several blank kinds, maxval at its top
    '{php_pkg::CHAR_P,            1'b0, 1'b0, 1'b0, NO_HDR},
    '{php_pkg::CHAR_SIX,          1'b0, 1'b0, 1'b0, NO_HDR},
    '{php_pkg::CHAR_HASH,         1'b0, 1'b0, 1'b0, NO_HDR},
    '{8'hFF,                      1'b0, 1'b0, 1'b0, NO_HDR},
    '{php_pkg::CHAR_LF,           1'b0, 1'b0, 1'b0, NO_HDR},
    '{php_pkg::CHAR_ZERO + 8'd9,  1'b0, 1'b0, 1'b0, NO_HDR},
    '{php_pkg::CHAR_SPACE,        1'b0, 1'b0, 1'b0, NO_HDR},
    '{php_pkg::CHAR_ZERO + 8'd7,  1'b0, 1'b0, 1'b0, NO_HDR},
    '{php_pkg::CHAR_TAB,          1'b0, 1'b0, 1'b0, NO_HDR},
    '{php_pkg::CHAR_ZERO + 8'd2,  1'b0, 1'b0, 1'b0, NO_HDR},
    '{php_pkg::CHAR_ZERO + 8'd5,  1'b0, 1'b0, 1'b0, NO_HDR},
    '{php_pkg::CHAR_ZERO + 8'd5,  1'b0, 1'b0, 1'b0, NO_HDR},
    '{8'h00,                      1'b0, 1'b1, 1'b0, HDR_9X7},
    // pixel byte after the header is ignored, then rearm
    '{8'hAA,                      1'b0, 1'b0, 1'b0, NO_HDR},
    '{8'h00,                      1'b1, 1'b0, 1'b0, NO_HDR},
    // byte that cannot start a token
    '{php_pkg::CHAR_P,            1'b0, 1'b0, 1'b0, NO_HDR},
    '{php_pkg::CHAR_SIX,          1'b0, 1'b0, 1'b0, NO_HDR},
    '{CHAR_X,                     1'b0, 1'b1, 1'b0, HDR_BROKEN},
    '{8'h00,                      1'b1, 1'b0, 1'b0, NO_HDR},
    // end of file inside maxval digits; maxval of zero is unsupported
    '{php_pkg::CHAR_P,            1'b0, 1'b0, 1'b0, NO_HDR},
    '{php_pkg::CHAR_SIX,          1'b0, 1'b0, 1'b0, NO_HDR},
    '{php_pkg::CHAR_ZERO + 8'd1,  1'b0, 1'b0, 1'b0, NO_HDR},
    '{php_pkg::CHAR_SPACE,        1'b0, 1'b0, 1'b0, NO_HDR},
    '{php_pkg::CHAR_ZERO + 8'd1,  1'b0, 1'b0, 1'b0, NO_HDR},
    '{php_pkg::CHAR_CR,           1'b0, 1'b0, 1'b0, NO_HDR},
    '{php_pkg::CHAR_ZERO,         1'b0, 1'b0, 1'b0, NO_HDR},
    '{8'h00,                      1'b1, 1'b1, 1'b0, HDR_UNSUP}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  php_in_if  byte_ch ();
  php_out_if hdr_ch ();

  ppm_header_parser_core uut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (byte_ch),
    .header (hdr_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser predictor. State starts at its reset values; end of file rearms it.
  // ---------------------------------------------------------------------------
  php_pkg::phase_t  ph      = php_pkg::PH_MAGIC0;
  logic [1:0]       tok_idx = '0;
  logic [DIM_W:0]   acc     = '0;   // saturates at 2^DIM_W
  logic [DIM_W-1:0] wid_q   = '0;
  logic [DIM_W-1:0] hgt_q   = '0;
  logic [OFF_W-1:0] seen    = '0;

  header_t    pending_headers [$];
  file_item_t file_bytes [$];
  file_item_t cur_item;
  logic [7:0] hdr_text [$];
  int         fault_count = 0;

  function automatic bit blank_byte(input logic [7:0] c);
    return c == php_pkg::CHAR_SPACE || (c >= php_pkg::CHAR_TAB && c <= php_pkg::CHAR_CR);
  endfunction

  function automatic bit digit_byte(input logic [7:0] c);
    return c >= php_pkg::CHAR_ZERO && c <= php_pkg::CHAR_ZERO + 8'd9;
  endfunction

  function automatic void clear_parser();
    ph      = php_pkg::PH_MAGIC0;
    tok_idx = '0;
    acc     = '0;
    wid_q   = '0;
    hgt_q   = '0;
    seen    = '0;
  endfunction

  function automatic header_t reject(input php_pkg::status_t s);
    header_t h;
    h        = '0;
    h.status = s;
    ph       = php_pkg::PH_DONE;
    return h;
  endfunction

  // maxval is whatever sits in the accumulator when the header ends
  function automatic header_t finish_header();
    header_t h;
    h = '0;
    if (wid_q == 0 || hgt_q == 0 || acc == 0 || acc > php_pkg::SAMPLE_LIMIT) begin
      h.status = php_pkg::ST_UNSUPPORTED;
    end else begin
      h.status     = php_pkg::ST_OK;
      h.width      = wid_q;
      h.height     = hgt_q;
      h.sample_max = acc[7:0];
      h.offset     = seen;
    end
    ph = php_pkg::PH_DONE;
    return h;
  endfunction

  // zero and out-of-range dimensions are both kept as zero
  function automatic logic [DIM_W-1:0] legal_dim();
    return (acc == 0 || acc[DIM_W]) ? '0 : acc[DIM_W-1:0];
  endfunction

  // one byte while looking for the start of a token
  function automatic bit skip_one(input logic [7:0] c, output header_t h);
    h = '0;
    if (blank_byte(c)) return 1'b0;
    if (c == php_pkg::CHAR_HASH) begin
      ph = php_pkg::PH_COMMENT;
      return 1'b0;
    end
    if (digit_byte(c)) begin
      acc = (DIM_W + 1)'(c - php_pkg::CHAR_ZERO);
      ph  = php_pkg::PH_DIGITS;
      return 1'b0;
    end
    h = reject(php_pkg::ST_MALFORMED);
    return 1'b1;
  endfunction

  // Returns 1 when this item produces a header result, placed in h.
  function automatic bit predict_header(input logic [7:0] c, input logic eof,
                                        output header_t h);
    bit         got;
    logic [23:0] grown;
    got = 1'b0;
    h   = '0;
    if (eof) begin
      case (ph)
        php_pkg::PH_MAGIC0, php_pkg::PH_MAGIC1, php_pkg::PH_MAGIC1_BAD: begin
          h   = reject(php_pkg::ST_MAGIC);
          got = 1'b1;
        end
        php_pkg::PH_SKIP, php_pkg::PH_COMMENT: begin
          h   = reject(php_pkg::ST_MALFORMED);
          got = 1'b1;
        end
        php_pkg::PH_DIGITS: begin
          h   = (tok_idx >= 2) ? finish_header() : reject(php_pkg::ST_MALFORMED);
          got = 1'b1;
        end
        default: ;
      endcase
      clear_parser();
      return got;
    end
    if (ph == php_pkg::PH_DONE) return 1'b0;
    if (seen != '1) seen++;
    case (ph)
      php_pkg::PH_MAGIC0: ph = (c == php_pkg::CHAR_P) ? php_pkg::PH_MAGIC1
                                                       : php_pkg::PH_MAGIC1_BAD;
      php_pkg::PH_MAGIC1: begin
        if (c != php_pkg::CHAR_SIX) begin
          h   = reject(php_pkg::ST_MAGIC);
          got = 1'b1;
        end else begin
          ph      = php_pkg::PH_SKIP;
          tok_idx = '0;
        end
      end
      php_pkg::PH_MAGIC1_BAD: begin
        h   = reject(php_pkg::ST_MAGIC);
        got = 1'b1;
      end
      php_pkg::PH_SKIP: got = skip_one(c, h);
      php_pkg::PH_COMMENT: if (c == php_pkg::CHAR_LF) ph = php_pkg::PH_SKIP;
      default: begin
        if (digit_byte(c)) begin
          grown = 24'(acc) * 24'd10 + 24'(c - php_pkg::CHAR_ZERO);
          acc   = (grown > (24'd1 << DIM_W)) ? (DIM_W + 1)'(1) << DIM_W
                                              : grown[DIM_W:0];
        end else if (tok_idx >= 2) begin
          h   = finish_header();
          got = 1'b1;
        end else begin
          // terminator of width or height is looked at again as skip input
          if (tok_idx == 0) wid_q = legal_dim();
          else              hgt_q = legal_dim();
          tok_idx++;
          acc = '0;
          ph  = php_pkg::PH_SKIP;
          got = skip_one(c, h);
        end
      end
    endcase
    return got;
  endfunction

  // ---------------------------------------------------------------------------
  // Random file builder: mostly well-formed headers with random content,
  // some noise, broken magic, junk between tokens and early end of file.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 6))
      0:       return php_pkg::CHAR_TAB;
      1:       return php_pkg::CHAR_LF;
      2:       return CHAR_VT;
      3:       return CHAR_FF;
      4:       return php_pkg::CHAR_CR;
      default: return php_pkg::CHAR_SPACE;
    endcase
  endfunction

  // non-blank, non-digit, non-'#', biased to the class boundaries
  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0: return 8'h08;
      1: return 8'h0E;
      2: return php_pkg::CHAR_ZERO - 8'd1;
      3: return php_pkg::CHAR_ZERO + 8'd10;
      default: begin
        c = 8'($urandom_range(0, 255));
        return (blank_byte(c) || digit_byte(c) || c == php_pkg::CHAR_HASH) ? CHAR_X : c;
      end
    endcase
  endfunction

  function automatic int unsigned pick_value(input bit for_max);
    case ($urandom_range(0, 15))
      0:       return 0;
      1:       return for_max ? 255 : 65535;
      2:       return for_max ? 256 : 65536;
      3:       return $urandom;          // long digit string, saturates
      4:       return 1;
      default: return for_max ? $urandom_range(1, 255) : $urandom_range(1, 640);
    endcase
  endfunction

  function automatic void add_gap(input bit need);
    logic [7:0] c;
    int         n;
    n = need ? $urandom_range(1, 3) : $urandom_range(0, 2);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) begin
        hdr_text.push_back(php_pkg::CHAR_HASH);
        repeat ($urandom_range(0, 4)) begin
          c = 8'($urandom_range(0, 255));
          hdr_text.push_back(c == php_pkg::CHAR_LF ? php_pkg::CHAR_HASH : c);
        end
        hdr_text.push_back(php_pkg::CHAR_LF);
      end else begin
        hdr_text.push_back(blank_char());
      end
    end
  endfunction

  function automatic void add_number(input int unsigned v);
    logic [7:0] digs [$];
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3)) hdr_text.push_back(php_pkg::CHAR_ZERO);
    do begin
      digs.push_front(php_pkg::CHAR_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digs[i]) hdr_text.push_back(digs[i]);
  endfunction

  // Builds one file into file_bytes, closed by an end-of-file item.
  function automatic void queue_file(input bit drain);
    int kind;
    int keep;
    kind = $urandom_range(0, 19);
    hdr_text.delete();
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) hdr_text.push_back(8'($urandom_range(0, 255)));
    end else if (kind == 1) begin
      if ($urandom_range(0, 1)) begin
        hdr_text.push_back(php_pkg::CHAR_P);
        hdr_text.push_back(junk_char());
      end else begin
        hdr_text.push_back(8'($urandom_range(0, 255)));
        hdr_text.push_back(php_pkg::CHAR_SIX);
      end
    end else begin
      hdr_text.push_back(php_pkg::CHAR_P);
      hdr_text.push_back(php_pkg::CHAR_SIX);
      add_gap(1'b0);
      add_number(pick_value(1'b0));
      if (kind == 2) hdr_text.push_back(junk_char());
      else           add_gap(1'b1);
      add_number(pick_value(1'b0));
      add_gap(1'b1);
      add_number(pick_value(1'b1));
      hdr_text.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                      : blank_char());
      // pixel bytes, ignored once the header is out
      repeat ($urandom_range(0, 4)) hdr_text.push_back(8'($urandom_range(0, 255)));
      if (kind == 3 || kind == 4) begin
        keep = $urandom_range(0, hdr_text.size() - 1);
        while (hdr_text.size() > keep) void'(hdr_text.pop_back());
      end
    end
    foreach (hdr_text[i])
      file_bytes.push_back('{hdr_text[i], 1'b0, 1'b0, drain && i == 0, NO_HDR});
    file_bytes.push_back('{8'($urandom_range(0, 255)), 1'b1, 1'b0,
                           drain && hdr_text.size() == 0, NO_HDR});
  endfunction

  function automatic void log_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Byte side: every accepted item runs through the predictor.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    header_t want;
    bit      got;
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      got = predict_header(cur_item.data_byte, cur_item.eof, want);
      if (cur_item.pinned) pending_headers.push_back(cur_item.want);
      else if (got)        pending_headers.push_back(want);
    end
  end

  // ---------------------------------------------------------------------------
  // Header side: compare each accepted result with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    header_t want;
    if (!rst && hdr_ch.valid && hdr_ch.ready) begin
      if (pending_headers.size() == 0) begin
        log_fault($sformatf("unexpected header: status %0d width %0d height %0d max %0d off %0d",
                            hdr_ch.status, hdr_ch.image_width, hdr_ch.image_height,
                            hdr_ch.sample_max, hdr_ch.data_offset));
      end else begin
        want = pending_headers.pop_front();
        if (hdr_ch.status !== want.status)
          log_fault($sformatf("status: expected %0d, got %0d", want.status, hdr_ch.status));
        if (hdr_ch.image_width !== want.width)
          log_fault($sformatf("image_width: expected %0d, got %0d",
                              want.width, hdr_ch.image_width));
        if (hdr_ch.image_height !== want.height)
          log_fault($sformatf("image_height: expected %0d, got %0d",
                              want.height, hdr_ch.image_height));
        if (hdr_ch.sample_max !== want.sample_max)
          log_fault($sformatf("sample_max: expected %0d, got %0d",
                              want.sample_max, hdr_ch.sample_max));
        if (hdr_ch.data_offset !== want.offset)
          log_fault($sformatf("data_offset: expected %0d, got %0d",
                              want.offset, hdr_ch.data_offset));
      end
    end
  end

  // Receiver: cycles through always-ready, coin-flip, 1-in-4 and long stalls.
  initial begin
    int unsigned tick;
    tick = 0;
    hdr_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      case (tick[9:8])
        2'd0:    hdr_ch.ready <= 1'b1;
        2'd1:    hdr_ch.ready <= 1'($urandom_range(0, 1));
        2'd2:    hdr_ch.ready <= (tick[1:0] == 2'd0);
        default: hdr_ch.ready <= (tick[3:0] == 4'hF);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and run control. Items change on the falling edge.
  // ---------------------------------------------------------------------------
  initial begin
    int n_files;
    int burst_left;
    byte_ch.valid       = 1'b0;
    byte_ch.data_byte   = '0;
    byte_ch.end_of_file = 1'b0;

    foreach (DIRECTED_ROWS[i]) file_bytes.push_back(DIRECTED_ROWS[i]);
    // every tenth random file waits for the pipe to run dry first,
    // the first one included
    n_files = 0;
    while (file_bytes.size() < N_DIRECTED + RANDOM_BYTES) begin
      queue_file(n_files % 10 == 0);
      n_files++;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    burst_left = 0;
    foreach (file_bytes[i]) begin
      @(negedge clk);
      if (file_bytes[i].drain || burst_left == 0) begin
        byte_ch.valid <= 1'b0;
        if (file_bytes[i].drain) begin
          do @(negedge clk); while (pending_headers.size() != 0);
        end else begin
          repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        // mostly short bursts, now and then a long unbroken stretch
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end
      burst_left--;
      cur_item             = file_bytes[i];
      byte_ch.valid       <= 1'b1;
      byte_ch.data_byte   <= file_bytes[i].data_byte;
      byte_ch.end_of_file <= file_bytes[i].eof;
      do @(posedge clk); while (!byte_ch.ready);
    end
    @(negedge clk);
    byte_ch.valid <= 1'b0;

    while (pending_headers.size() != 0) @(posedge clk);
    // the output and skid registers may still hold a result; catch any stray one
    repeat (16) @(posedge clk);
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/php_pkg.sv
hdl/php_if.sv
hdl/php_parse.sv
hdl/php_out_buf.sv
hdl/ppm_header_parser_core.sv
bench/ppm_header_parser_core_test.sv
